// File: hw/rtl/waypoint_line_interpolator_top_assert.svh
// assertion macros shared by the waypoint interpolator modules
// depends on nothing; included inside module bodies
`ifndef WAYPOINT_LINE_INTERPOLATOR_TOP_ASSERT_SVH
`define WAYPOINT_LINE_INTERPOLATOR_TOP_ASSERT_SVH

// implication checked on every edge outside reset
`define WLI_ASSERT_IMP(label, lhs, rhs, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) else $error(msg);

// implication whose consequent is checked in the cycle after the antecedent
`define WLI_ASSERT_NEXT(label, lhs, rhs, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) else $error(msg);

`endif

// File: hw/rtl/wli_pkg.sv
// shared types and constants of the waypoint line interpolator
// depends on nothing
`default_nettype none
package wli_pkg;
  localparam int COORD_WIDTH_DEF = 16;
  localparam int MAX_STEPS_DEF   = 63;
  localparam int RES_WIDTH       = 15;
  localparam logic [RES_WIDTH-1:0] RES_RESET = 15'd51;

  typedef struct packed {
    logic signed [COORD_WIDTH_DEF-1:0] waypoint_x;
    logic signed [COORD_WIDTH_DEF-1:0] waypoint_y;
    logic                              path_start;
  } wli_in_t;

  typedef struct packed {
    logic signed [COORD_WIDTH_DEF-1:0] point_x;
    logic signed [COORD_WIDTH_DEF-1:0] point_y;
    logic                              segment_last;
  } wli_out_t;
endpackage
`default_nettype wire

// File: hw/rtl/waypoint_line_interpolator_top.sv
// Waypoint line interpolator. Each waypoint that continues a path produces
// ceil(ceil(sqrt(dx^2+dy^2))/step_resolution)+1 points (step count capped at
// MAX_STEPS), the last one flagged with segment_last; a repeated waypoint gives
// only its start point, flagged last. The back takes a segment from the queue
// whenever it is idle, then runs the bit-serial square root, a rounding step and
// the step-count divider before it offers the first point, the start. Each
// further point comes from the shared bit-serial divider that forms delta*j/n
// on each axis in turn, and is formed only once out_stall has let the point
// before it go. The front holds the previous waypoint and a two-entry segment
// queue lets it keep taking waypoints while the back is still emitting points.
// depends on wli_pkg and the front, queue and back modules
`default_nettype none
module waypoint_line_interpolator_top
  import wli_pkg::*;
#(
  parameter int MAX_STEPS = MAX_STEPS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [RES_WIDTH-1:0] cfg_wdata,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire wli_in_t              in_data,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output wli_out_t                  out_data
);
  localparam int CW = COORD_WIDTH_DEF;
  logic [RES_WIDTH-1:0] step_resolution;
  logic seg_valid, seg_stall, q_valid, q_take;
  logic [4*CW-1:0] seg_data, q_data;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) step_resolution <= RES_RESET;
    else if (cfg_we) step_resolution <= cfg_wdata;
  end

  wli_front #(.CW(CW)) u_front (
    .clk, .rst, .in_valid, .in_stall,
    .in_x(in_data.waypoint_x), .in_y(in_data.waypoint_y), .in_start(in_data.path_start),
    .seg_valid, .seg_stall, .seg_data
  );

  wli_queue #(.W(4*CW)) u_queue (
    .clk, .rst, .wr_valid(seg_valid), .wr_stall(seg_stall), .wr_data(seg_data),
    .rd_valid(q_valid), .rd_take(q_take), .rd_data(q_data)
  );

  wli_back #(.CW(CW), .MAX_STEPS(MAX_STEPS)) u_back (
    .clk, .rst, .resolution(step_resolution),
    .seg_valid(q_valid), .seg_take(q_take), .seg_data(q_data),
    .out_valid, .out_stall,
    .out_x(out_data.point_x), .out_y(out_data.point_y), .out_last(out_data.segment_last)
  );
endmodule
`default_nettype wire

// File: hw/rtl/wli_front.sv
// front part: keeps the previous waypoint and turns waypoints into segments
// depends on wli_pkg
`default_nettype none
module wli_front
  import wli_pkg::*;
#(
  parameter int CW = COORD_WIDTH_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_stall,
  input  wire logic [CW-1:0]   in_x,
  input  wire logic [CW-1:0]   in_y,
  input  wire logic            in_start,
  output logic                 seg_valid,
  input  wire logic            seg_stall,
  output logic [4*CW-1:0]      seg_data
);
  logic [CW-1:0] previous_x, previous_y;
  logic          have_previous;
  logic          accept;

  assign in_stall  = seg_stall;
  assign accept    = in_valid && !seg_stall;
  // only continuing waypoints form a segment
  assign seg_valid = in_valid && !in_start && have_previous;
  assign seg_data  = {previous_x, previous_y, in_x, in_y};

  // previous waypoint register
  always_ff @(posedge clk) begin
    if (rst) begin
      previous_x    <= '0;
      previous_y    <= '0;
      have_previous <= 1'b0;
    end else if (accept) begin
      previous_x    <= in_x;
      previous_y    <= in_y;
      have_previous <= 1'b1;
    end
  end
endmodule
`default_nettype wire

// File: hw/rtl/wli_queue.sv
// two-entry segment queue between front and back
// depends on wli_pkg and waypoint_line_interpolator_top_assert.svh
`default_nettype none
module wli_queue
  import wli_pkg::*;
#(
  parameter int W = 64
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         wr_valid,
  output logic              wr_stall,
  input  wire logic [W-1:0] wr_data,
  output logic              rd_valid,
  input  wire logic         rd_take,
  output logic [W-1:0]      rd_data
);
  logic [W-1:0] mem [2];
  logic         wptr, rptr;
  logic [1:0]   count;
  logic         push, pop;

  assign wr_stall = (count == 2'd2);
  assign rd_valid = (count != 2'd0);
  assign push     = wr_valid && !wr_stall;
  assign pop      = rd_take && rd_valid;
  assign rd_data  = mem[rptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) mem[wptr] <= wr_data;
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wptr <= ~wptr;
      if (pop)  rptr <= ~rptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  `include "waypoint_line_interpolator_top_assert.svh"
  `WLI_ASSERT_IMP(a_no_overflow, count == 2'd2, !push, "queue push when full")
  `WLI_ASSERT_IMP(a_count_range, 1'b1, count != 2'd3, "queue count out of range")
  `WLI_ASSERT_NEXT(a_pop_moves, pop && !push, count == $past(count) - 2'd1, "pop lost")
endmodule
`default_nettype wire

// File: hw/rtl/wli_back.sv
// back part: square root, step count, and point emission by serial division
// depends on wli_pkg and waypoint_line_interpolator_top_assert.svh
`default_nettype none
module wli_back
  import wli_pkg::*;
#(
  parameter int CW        = COORD_WIDTH_DEF,
  parameter int MAX_STEPS = MAX_STEPS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic [RES_WIDTH-1:0] resolution,
  input  wire logic                 seg_valid,
  output logic                      seg_take,
  input  wire logic [4*CW-1:0]      seg_data,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [CW-1:0]             out_x,
  output logic [CW-1:0]             out_y,
  output logic                      out_last
);
  localparam int DW = CW + 1;            // delta width
  localparam int AW = CW;                // magnitude width
  localparam int SW = 2 * AW + 1;        // sum of squares width
  localparam int RW = AW + 1;            // root width
  localparam int NW = $clog2(MAX_STEPS + 1);
  localparam int PW = DW + NW;           // product width
  localparam int LW = (RW > RES_WIDTH) ? RW + 1 : RES_WIDTH + 1;
  localparam int SQ_IT = (SW + 1) / 2;
  localparam int CNT_W = $clog2((SQ_IT > PW ? SQ_IT : PW) + LW + 2);

  localparam logic [2:0] S_IDLE = 3'd0, S_SQ = 3'd1, S_CEIL = 3'd2,
                         S_DIV = 3'd3, S_PT = 3'd4, S_EMIT = 3'd5;

  logic [2:0] state;
  logic [CW-1:0] sx, sy;
  logic signed [DW-1:0] dx, dy;
  logic [2*SQ_IT-1:0] sq_val;
  logic [RW:0] root;
  logic [SW:0] rem;
  logic [CNT_W-1:0] cnt;
  logic [LW-1:0] lnum, lq, lr;
  logic [LW-1:0] lq_final;
  logic [NW-1:0] n, j;
  logic [PW-1:0] num, q, r;
  logic axis, negq;
  logic [CW-1:0] px;
  logic signed [DW-1:0] ax_s, ay_s;
  logic [AW:0] mx, my;
  logic [DW-1:0] mag_dx, mag_dy;
  logic [RES_WIDTH-1:0] res;
  logic [SW+2:0] trial;
  logic [LW:0] ltrial;
  logic [PW:0] ptrial;
  logic [PW-1:0] qf;
  logic signed [PW:0] qs;

  assign res = (resolution == '0) ? {{(RES_WIDTH-1){1'b0}}, 1'b1} : resolution;
  assign ax_s = $signed({seg_data[2*CW-1], seg_data[2*CW-1:CW]})
              - $signed({seg_data[4*CW-1], seg_data[4*CW-1:3*CW]});
  assign ay_s = $signed({seg_data[CW-1], seg_data[CW-1:0]})
              - $signed({seg_data[3*CW-1], seg_data[3*CW-1:2*CW]});
  assign mx = ax_s[DW-1] ? (AW+1)'(0) - ax_s[AW:0] : ax_s[AW:0];
  assign my = ay_s[DW-1] ? (AW+1)'(0) - ay_s[AW:0] : ay_s[AW:0];
  assign mag_dx = dx[DW-1] ? $unsigned(-dx) : $unsigned(dx);
  assign mag_dy = dy[DW-1] ? $unsigned(-dy) : $unsigned(dy);
  assign seg_take = (state == S_IDLE) && seg_valid;
  assign out_valid = (state == S_EMIT);
  assign trial  = {rem, sq_val[2*SQ_IT-1 -: 2]} - {(SW-RW)'(0), root, 2'b01};
  assign ltrial = {lr, lnum[LW-1]} - {1'b0, (LW-RES_WIDTH)'(0), res};
  assign ptrial = {r, num[PW-1]} - {1'b0, (PW-NW)'(0), n};
  // quotient of the step-count division including its last digit
  assign lq_final = {lq[LW-2:0], !ltrial[LW]};
  // floor of a signed quotient from the magnitude quotient and remainder
  assign qf = (negq && (r != '0)) ? q + PW'(1) : q;
  assign qs = negq ? -$signed({1'b0, qf}) : $signed({1'b0, qf});

  // sequencer: root digit by digit, ceil divide, then per-point long division
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (seg_valid) begin
            sx <= seg_data[4*CW-1:3*CW];
            sy <= seg_data[3*CW-1:2*CW];
            dx <= ax_s;
            dy <= ay_s;
            sq_val <= (2*SQ_IT)'(mx * mx) + (2*SQ_IT)'(my * my);
            root <= '0;
            rem <= '0;
            cnt <= CNT_W'(SQ_IT);
            state <= S_SQ;
          end
        end
        S_SQ: begin
          sq_val <= sq_val << 2;
          if (!trial[SW+2]) begin
            rem <= trial[SW:0];
            root <= {root[RW-1:0], 1'b1};
          end else begin
            rem <= {rem[SW-2:0], sq_val[2*SQ_IT-1 -: 2]};
            root <= {root[RW-1:0], 1'b0};
          end
          cnt <= cnt - CNT_W'(1);
          if (cnt == CNT_W'(1)) state <= S_CEIL;
        end
        S_CEIL: begin
          // ceil root, then numerator root + res - 1 for the ceil division
          lnum <= LW'(root) + LW'(rem != '0) + LW'(res) - LW'(1);
          lq <= '0;
          lr <= '0;
          cnt <= CNT_W'(LW);
          state <= S_DIV;
        end
        S_DIV: begin
          lnum <= lnum << 1;
          if (!ltrial[LW]) begin
            lr <= ltrial[LW-1:0];
            lq <= {lq[LW-2:0], 1'b1};
          end else begin
            lr <= {lr[LW-2:0], lnum[LW-1]};
            lq <= {lq[LW-2:0], 1'b0};
          end
          cnt <= cnt - CNT_W'(1);
          // first point is the start; saturate step count, zero length ends here
          if (cnt == CNT_W'(1)) begin
            j <= '0;
            axis <= 1'b0;
            state <= S_EMIT;
            out_x <= sx;
            out_y <= sy;
            if (lq_final == '0) begin
              n <= '0;
              out_last <= 1'b1;
            end else if (lq_final > LW'(MAX_STEPS)) begin
              n <= NW'(MAX_STEPS);
              out_last <= 1'b0;
            end else begin
              n <= NW'(lq_final);
              out_last <= 1'b0;
            end
          end
        end
        S_PT: begin
          if (cnt != CNT_W'(0)) begin
            num <= num << 1;
            if (!ptrial[PW]) begin
              r <= ptrial[PW-1:0];
              q <= {q[PW-2:0], 1'b1};
            end else begin
              r <= {r[PW-2:0], num[PW-1]};
              q <= {q[PW-2:0], 1'b0};
            end
            cnt <= cnt - CNT_W'(1);
          end else if (!axis) begin
            // x done, load |dy|*j for the y axis
            px <= sx + CW'(qs);
            axis <= 1'b1;
            num <= PW'(mag_dy) * PW'(j);
            negq <= dy[DW-1];
            q <= '0;
            r <= '0;
            cnt <= CNT_W'(PW);
          end else begin
            out_x <= px;
            out_y <= sy + CW'(qs);
            out_last <= (j == n);
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (!out_stall) begin
            if (out_last) begin
              state <= S_IDLE;
            end else begin
              // next point, load |dx|*j for the x axis
              j <= j + NW'(1);
              axis <= 1'b0;
              num <= PW'(mag_dx) * PW'(j + NW'(1));
              negq <= dx[DW-1];
              q <= '0;
              r <= '0;
              cnt <= CNT_W'(PW);
              state <= S_PT;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `include "waypoint_line_interpolator_top_assert.svh"
  `WLI_ASSERT_IMP(a_take_idle, seg_take, state == S_IDLE, "segment taken while busy")
  `WLI_ASSERT_IMP(a_j_bound, state == S_EMIT, j <= n || n == '0, "point index past step count")
  `WLI_ASSERT_NEXT(a_hold, out_valid && out_stall, out_valid && $stable(out_x), "output dropped")
endmodule
`default_nettype wire

// File: tb/sv/tb_top.sv
// testbench for the waypoint line interpolator: directed table then random waypoints
// depends on wli_pkg and waypoint_line_interpolator_top
`default_nettype none
module tb_top;
  import wli_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_STEPS = MAX_STEPS_DEF;
  // per point cost of the serial divider plus slack, in cycles
  localparam int DRAIN_CYCLES = 400;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [RES_WIDTH-1:0] cfg_wdata;
  logic in_valid;
  logic in_stall;
  wli_in_t in_data;
  logic out_valid;
  logic out_stall;
  wli_out_t out_data;

  waypoint_line_interpolator_top #(.MAX_STEPS(MAX_STEPS)) DUT (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  // predictor state
  logic signed [15:0] prev_x, prev_y;
  logic have_prev;
  logic [RES_WIDTH-1:0] resolution;

  wli_out_t pending_points[$];
  int mismatch_count = 0;
  int point_count = 0;
  int waypoint_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  // directed table row
  typedef struct {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic start;
    int exp_points; // -1 when left to the predictor
  } waypoint_row_t;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("waypoint_line_interpolator_top: mismatch");
    $finish;
  end

  function automatic longint div_floor(longint num, longint den);
    longint q;
    q = num / den;
    if ((num % den) != 0 && num < 0) q = q - 1;
    return q;
  endfunction

  function automatic longint root_ceil(longint v);
    longint r;
    r = 0;
    while ((r + 1) * (r + 1) <= v) r++;
    if (r * r < v) r++;
    return r;
  endfunction

  // works out the points of one waypoint, returns how many
  function automatic int interpolate_waypoint(wli_in_t w);
    longint dx, dy, len, res, steps, j;
    wli_out_t p;
    if (w.path_start || !have_prev) begin
      prev_x = w.waypoint_x;
      prev_y = w.waypoint_y;
      have_prev = 1'b1;
      return 0;
    end
    dx = longint'(w.waypoint_x) - longint'(prev_x);
    dy = longint'(w.waypoint_y) - longint'(prev_y);
    res = (resolution == 0) ? 1 : resolution;
    len = root_ceil(dx * dx + dy * dy);
    steps = (len + res - 1) / res;
    if (steps > MAX_STEPS) steps = MAX_STEPS;
    if (steps == 0) begin
      p.point_x = prev_x;
      p.point_y = prev_y;
      p.segment_last = 1'b1;
      pending_points.insert(pending_points.size(), p);
    end else begin
      for (j = 0; j <= steps; j++) begin
        p.point_x = 16'(longint'(prev_x) + div_floor(dx * j, steps));
        p.point_y = 16'(longint'(prev_y) + div_floor(dy * j, steps));
        p.segment_last = (j == steps);
        pending_points.insert(pending_points.size(), p);
      end
    end
    prev_x = w.waypoint_x;
    prev_y = w.waypoint_y;
    return int'(steps) + 1;
  endfunction

  task automatic report_mismatch(string what);
    mismatch_count++;
    $display("error at %0t: %s", $realtime, what);
  endtask

  // output side: random stall and compare
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        point_count++;
        if (pending_points.size() == 0) begin
          report_mismatch($sformatf("unexpected point %h", out_data));
        end else begin
          if (out_data.point_x !== pending_points[0].point_x)
            report_mismatch($sformatf("point_x %h, want %h", out_data.point_x,
                                      pending_points[0].point_x));
          if (out_data.point_y !== pending_points[0].point_y)
            report_mismatch($sformatf("point_y %h, want %h", out_data.point_y,
                                      pending_points[0].point_y));
          if (out_data.segment_last !== pending_points[0].segment_last)
            report_mismatch($sformatf("segment_last %b, want %b",
                                      out_data.segment_last,
                                      pending_points[0].segment_last));
          void'(pending_points.pop_front());
        end
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // hand one waypoint over and predict its points; valid stays up afterwards
  task automatic send_waypoint(wli_in_t w, output int n_points);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    n_points = interpolate_waypoint(w);
    waypoint_count++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_resolution(logic [RES_WIDTH-1:0] value);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    resolution = value;
  endtask

  function automatic logic signed [15:0] random_coord(int span);
    if (span >= 32768) return 16'($urandom);
    return 16'($signed($urandom_range(2 * span)) - span);
  endfunction

  waypoint_row_t directed[] = '{
    '{16'sd100, 16'sd100, 1'b0, 0},       // no previous waypoint yet
    '{16'sd100, 16'sd100, 1'b0, 1},       // zero-length segment
    '{16'sd151, 16'sd100, 1'b0, 2},       // exactly one resolution step
    '{16'sd152, 16'sd100, 1'b0, 2},
    '{16'sd0, 16'sd0, 1'b1, 0},           // new path
    '{16'sd30, 16'sd40, 1'b0, 2},         // 3-4-5 triangle, length 50
    '{-16'sd30, -16'sd40, 1'b0, 3},
    '{16'sh7fff, 16'sh7fff, 1'b1, 0},
    '{-16'sh8000, -16'sh8000, 1'b0, MAX_STEPS + 1}, // largest span
    '{16'sh7fff, -16'sh8000, 1'b0, MAX_STEPS + 1},
    '{-16'sd1, 16'sd0, 1'b1, 0},
    '{16'sd0, 16'sd0, 1'b0, 2},
    '{16'sd0, -16'sd7, 1'b0, -1},
    '{16'sd5, 16'sd3, 1'b0, -1},
    '{-16'sd9, 16'sd20, 1'b0, -1}
  };

  initial begin
    int n_points;
    int span;
    wli_in_t w;
    logic [RES_WIDTH-1:0] res_settings[4];
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    prev_x = 0;
    prev_y = 0;
    have_prev = 1'b0;
    resolution = RES_RESET;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table at the reset resolution
    foreach (directed[i]) begin
      w.waypoint_x = directed[i].x;
      w.waypoint_y = directed[i].y;
      w.path_start = directed[i].start;
      send_waypoint(w, n_points);
      if (directed[i].exp_points >= 0 && n_points != directed[i].exp_points)
        report_mismatch($sformatf("row %0d gives %0d points, want %0d", i,
                                  n_points, directed[i].exp_points));
    end
    wait_drained();

    // random phases, each with its own resolution and idling mix
    res_settings = '{15'd1, 15'h7fff, 15'd200, 15'd0};
    for (int phase = 0; phase < 4; phase++) begin
      write_resolution(res_settings[phase]);
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 58; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 58; end
        default: begin send_idle_pct = 21; recv_stall_pct = 21; end
      endcase
      for (int k = 0; k < 24; k++) begin
        // mostly short hops, now and then a long one or a repeat
        case ($urandom_range(9))
          0: span = 32768;
          1: span = 0;
          2, 3: span = 2000;
          default: span = 60;
        endcase
        if (span == 0) begin
          w.waypoint_x = prev_x;
          w.waypoint_y = prev_y;
        end else if (span == 32768 || !have_prev) begin
          w.waypoint_x = random_coord(span);
          w.waypoint_y = random_coord(span);
        end else begin
          w.waypoint_x = 16'(prev_x + random_coord(span));
          w.waypoint_y = 16'(prev_y + random_coord(span));
        end
        w.path_start = ($urandom_range(9) == 0);
        send_waypoint(w, n_points);
        // hold off once until every point is out
        if (phase == 1 && k == 10) wait_drained();
      end
      wait_drained();
    end

    $display("sent %0d waypoints, checked %0d points over 5 resolutions",
             waypoint_count, point_count);
    if (mismatch_count == 0 && pending_points.size() == 0) begin
      $display("waypoint_line_interpolator_top: match");
    end else begin
      $display("waypoint_line_interpolator_top: mismatch");
    end
    $finish;
  end
endmodule
`default_nettype wire

// File: filelist.f
+incdir+hw/rtl
hw/rtl/wli_pkg.sv
hw/rtl/wli_front.sv
hw/rtl/wli_queue.sv
hw/rtl/wli_back.sv
hw/rtl/waypoint_line_interpolator_top.sv
tb/sv/tb_top.sv
